[rtl/pidc_pkg.sv]
package pidc_pkg;

    localparam int ErrW     = 32;
    localparam int DtW      = 24;
    localparam int GainW    = 32;
    localparam int LimW     = 31;
    localparam int IntW     = 48;
    localparam int TermW    = IntW + 1;
    localparam int SumW     = TermW + 2;
    localparam int ProdW    = GainW + DtW;
    localparam int AccW     = ProdW + DtW;
    localparam int FracW    = 16;
    localparam int DivW     = ErrW + 1 + FracW;
    localparam int DivSteps = DivW;
    localparam int DivCntW  = $clog2(DivSteps + 1);
    localparam int DerW     = IntW - 1;

    // operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        OP_P,
        OP_INC,
        OP_I,
        OP_D
    } op_t;

    typedef enum logic [1:0] {
        REG_P_GAIN,
        REG_I_GAIN,
        REG_D_GAIN,
        REG_MAX_OUT
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic clear_state;
        logic div_start;
        op_t  op;
        logic mul_lo;
        logic mul_hi;
        logic mul_acc;
        logic add_sum;
        logic add_int;
        logic store_err;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic use_i;
        logic use_d;
        logic dt_zero;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

[rtl/pidc_div.sv]
module pidc_div
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DivW-1:0]   dividend,
    input  logic [DtW-1:0]    divisor,
    output logic              busy,
    output logic [DivW-1:0]   quotient
);

    logic               busy_reg, busy_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic [DivW-1:0]    num_reg, num_next;
    logic [DtW-1:0]     rem_reg, rem_next;
    logic [DtW:0]       rem_shift;
    logic               fits;

    // restoring division, one quotient bit per cycle; quotient bits shift in
    // behind the dividend bits
    always_comb
    begin
        rem_shift = {rem_reg, num_reg[DivW-1]};
        fits      = rem_shift >= {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DivCntW'(DivSteps);
            num_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DivW-2:0], fits};
            rem_next = fits ? DtW'(rem_shift - {1'b0, divisor}) : rem_shift[DtW-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DivCntW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

[rtl/pidc_dp.sv]
module pidc_dp
    import pidc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               in_kind,
    input  logic [ErrW-1:0]    in_err,
    input  logic [DtW-1:0]     in_dt,
    input  logic [GainW-1:0]   p_gain,
    input  logic [GainW-1:0]   i_gain,
    input  logic [GainW-1:0]   d_gain,
    input  logic [LimW-1:0]    max_out,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [ErrW-1:0]    out_drive,
    output logic               out_clamped,
    output logic               out_zero_step
);

    logic                   kind_reg;
    logic [ErrW-1:0]        err_reg;
    logic [DtW-1:0]         dt_reg;
    logic signed [IntW-1:0] integ_reg, integ_next;
    logic [ErrW-1:0]        last_err_reg;
    logic signed [SumW-1:0] sum_reg, sum_next;
    logic [ProdW-1:0]       prod_reg, prod_next;
    logic [AccW-1:0]        acc_reg;
    logic                   out_valid_reg;
    logic [ErrW-1:0]        drive_reg, drive_next;
    logic                   clamped_reg, clamped_next;
    logic                   zstep_reg;

    logic                   p_pos, i_pos, d_pos, full_mode, use_i, use_d;
    logic signed [ErrW:0]   diff;
    logic [ErrW:0]          diff_mag;
    logic [DivW-1:0]        quotient;
    logic                   div_busy;
    logic [DerW-1:0]        der_mag;
    logic [GainW-1:0]       a_mag;
    logic [IntW-1:0]        b_mag;
    logic [DtW-1:0]         b_part;
    logic                   neg;
    logic [IntW-1:0]        m_sat;
    logic signed [TermW-1:0] term;
    logic signed [IntW+1:0] int_wide;
    logic signed [SumW-1:0] limit, neg_limit;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [IntW-1:0] mag48(input logic [IntW-1:0] x);
        return x[IntW-1] ? (~x + IntW'(1)) : x;
    endfunction

    // mode from the gain signs
    assign p_pos     = !p_gain[GainW-1] && (p_gain != '0);
    assign i_pos     = !i_gain[GainW-1] && (i_gain != '0);
    assign d_pos     = !d_gain[GainW-1] && (d_gain != '0);
    assign full_mode = !p_pos || (i_pos && d_pos);
    assign use_i     = full_mode || i_pos;
    assign use_d     = full_mode || d_pos;

    assign diff     = $signed({err_reg[ErrW-1], err_reg})
                    - $signed({last_err_reg[ErrW-1], last_err_reg});
    assign diff_mag = diff[ErrW] ? (~diff + 1'b1) : diff;

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({diff_mag, {FracW{1'b0}}}),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign der_mag = (quotient[DivW-1:DerW] != '0) ? {DerW{1'b1}} : quotient[DerW-1:0];

    always_comb
    begin
        case (cmd.op)
            OP_P:
            begin
                a_mag = mag32(p_gain);
                b_mag = {{(IntW-ErrW){1'b0}}, mag32(err_reg)};
                neg   = p_gain[GainW-1] ^ err_reg[ErrW-1];
            end
            OP_INC:
            begin
                a_mag = mag32(err_reg);
                b_mag = {{(IntW-DtW){1'b0}}, dt_reg};
                neg   = err_reg[ErrW-1];
            end
            OP_I:
            begin
                a_mag = mag32(i_gain);
                b_mag = mag48(integ_reg);
                neg   = i_gain[GainW-1] ^ integ_reg[IntW-1];
            end
            default:
            begin
                a_mag = mag32(d_gain);
                b_mag = {1'b0, der_mag};
                neg   = d_gain[GainW-1] ^ diff[ErrW];
            end
        endcase
    end

    // 32x24 multiplier, low half of b then high half, summed in acc_reg
    assign b_part    = cmd.mul_hi ? b_mag[IntW-1:DtW] : b_mag[DtW-1:0];
    assign prod_next = ProdW'(a_mag) * ProdW'(b_part);

    assign m_sat = (acc_reg[AccW-1:IntW+FracW] != '0) ? {IntW{1'b1}}
                                                      : acc_reg[IntW+FracW-1:FracW];
    assign term  = neg ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});

    always_comb
    begin
        int_wide = $signed({{2{integ_reg[IntW-1]}}, integ_reg})
                 + $signed({term[TermW-1], term});
        if (int_wide[IntW+1:IntW-1] == 3'b000 || int_wide[IntW+1:IntW-1] == 3'b111)
        begin
            integ_next = int_wide[IntW-1:0];
        end
        else if (int_wide[IntW+1])
        begin
            integ_next = {1'b1, {(IntW-1){1'b0}}};
        end
        else
        begin
            integ_next = {1'b0, {(IntW-1){1'b1}}};
        end
    end

    assign sum_next = sum_reg + $signed({{(SumW-TermW){term[TermW-1]}}, term});

    assign limit     = $signed({{(SumW-LimW){1'b0}}, max_out});
    assign neg_limit = -limit;

    always_comb
    begin
        clamped_next = 1'b0;
        drive_next   = sum_reg[ErrW-1:0];
        if (sum_reg > limit)
        begin
            clamped_next = 1'b1;
            drive_next   = {1'b0, max_out};
        end
        else if (sum_reg < neg_limit)
        begin
            clamped_next = 1'b1;
            drive_next   = ~{1'b0, max_out} + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_state)
            begin
                integ_reg    <= '0;
                last_err_reg <= '0;
            end
            else
            begin
                if (cmd.add_int)
                begin
                    integ_reg <= integ_next;
                end
                if (cmd.store_err)
                begin
                    last_err_reg <= err_reg;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            err_reg  <= in_err;
            dt_reg   <= in_dt;
            sum_reg  <= '0;
        end
        else if (cmd.add_sum)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= {{(AccW-ProdW){1'b0}}, prod_reg};
        end
        else if (cmd.mul_acc)
        begin
            acc_reg <= acc_reg + {prod_reg, {DtW{1'b0}}};
        end
        if (cmd.out_load)
        begin
            drive_reg   <= drive_next;
            clamped_reg <= clamped_next;
            zstep_reg   <= use_d && (dt_reg == '0) && !kind_reg;
        end
    end

    assign sts.kind     = kind_reg;
    assign sts.use_i    = use_i;
    assign sts.use_d    = use_d;
    assign sts.dt_zero  = (dt_reg == '0);
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_drive     = drive_reg;
    assign out_clamped   = clamped_reg;
    assign out_zero_step = zstep_reg;

endmodule

[rtl/pidc_ctrl.sv]
module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MLO,
        S_MHI,
        S_MACC,
        S_TERM,
        S_DWAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   need_div;

    assign need_div = sts.use_d && !sts.dt_zero;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (sts.kind)
                begin
                    cmd.clear_state = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.div_start = need_div;
                    op_next       = OP_P;
                    state_next    = S_MLO;
                end
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = S_TERM;
            end
            S_TERM:
            begin
                case (op_reg)
                    OP_P:
                    begin
                        cmd.add_sum = 1'b1;
                        if (sts.use_i)
                        begin
                            op_next    = OP_INC;
                            state_next = S_MLO;
                        end
                        else
                        begin
                            state_next = need_div ? S_DWAIT : S_DONE;
                        end
                    end
                    OP_INC:
                    begin
                        cmd.add_int = 1'b1;
                        op_next     = OP_I;
                        state_next  = S_MLO;
                    end
                    OP_I:
                    begin
                        cmd.add_sum = 1'b1;
                        state_next  = need_div ? S_DWAIT : S_DONE;
                    end
                    default:
                    begin
                        cmd.add_sum = 1'b1;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_DWAIT:
            begin
                if (!sts.div_busy)
                begin
                    op_next    = OP_D;
                    state_next = S_MLO;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.store_err = sts.use_d && !sts.kind;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_P;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

`ifndef SYNTHESIS
    a_der_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MLO && op_reg == OP_D) |-> !sts.div_busy)
        else $error("derivative product started before the quotient was ready");

    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider restarted while still running");

    a_int_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_int |-> (sts.use_i && !sts.kind))
        else $error("integrator updated in a mode without an integral term");
`endif

endmodule

[rtl/pid_controller_clamped.sv]
// clamped pid controller, q16.16 fixed point
// config: apb-style port, registers at byte addresses 0 p_gain, 4 i_gain,
// 8 d_gain, 12 max_out; pready is always high, reads return the register.
// write registers only while no item is in flight.
// input stream: s_tuser selects the item kind (0 update, 1 clear stores),
// s_tdata carries error_in and time_step. one item is worked on at a time.
// output stream: one transfer per input item with drive, clamped, zero_step.
// the 49-step serial divider for the derivative is started ahead of the
// products before it (one in pd, three in pid), which run beside it on
// one shared 32x24 multiplier, each product passing the states mlo, mhi,
// macc and term. with a zero time step the divider is not started and
// the derivative product is skipped. the next item can be taken in the
// cycle after a result is loaded into the output register; a stalled
// receiver holds one result there while the block works on the next
// item, and that item then waits until the result leaves.
// reset clears gains, limit, integrator and previous error, and drops
// m_tvalid.
module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // error_in[31:0], time_step[55:32]
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // drive[31:0], clamped[32], zero_step[33], zero
);

    logic [GainW-1:0] p_gain_reg, i_gain_reg, d_gain_reg;
    logic [LimW-1:0]  max_out_reg;
    logic             wr_en;
    reg_idx_t         reg_idx;
    cmd_t             cmd;
    sts_t             sts;
    logic [ErrW-1:0]  drive;
    logic             clamped, zero_step;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg  <= '0;
            i_gain_reg  <= '0;
            d_gain_reg  <= '0;
            max_out_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_P_GAIN:  p_gain_reg  <= pwdata;
                REG_I_GAIN:  i_gain_reg  <= pwdata;
                REG_D_GAIN:  d_gain_reg  <= pwdata;
                REG_MAX_OUT: max_out_reg <= pwdata[LimW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_P_GAIN:  prdata = p_gain_reg;
            REG_I_GAIN:  prdata = i_gain_reg;
            REG_D_GAIN:  prdata = d_gain_reg;
            REG_MAX_OUT: prdata = {1'b0, max_out_reg};
        endcase
    end

    pidc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pidc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (s_tuser),
        .in_err        (s_tdata[31:0]),
        .in_dt         (s_tdata[55:32]),
        .p_gain        (p_gain_reg),
        .i_gain        (i_gain_reg),
        .d_gain        (d_gain_reg),
        .max_out       (max_out_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_drive     (drive),
        .out_clamped   (clamped),
        .out_zero_step (zero_step)
    );

    assign m_tdata = {6'b0, zero_step, clamped, drive};

endmodule

[sim/pidc_tb_pkg.sv]
package pidc_tb_pkg;

    // meaning of s_tuser on an input transfer
    typedef enum logic {
        ITEM_UPDATE,
        ITEM_CLEAR
    } item_kind_t;

endpackage

[sim/pid_controller_clamped_chk.sv]
module pid_controller_clamped_chk
    import pidc_pkg::*, pidc_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // error_in[31:0], time_step[55:32]
    input  logic        s_tuser,   // kind
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // drive[31:0], clamped[32], zero_step[33], zero
    output int          mismatches,
    output int          results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TermLim = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint AccMax  = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint AccMin  = -AccMax - 1;

    typedef struct packed {
        logic [31:0] drive;
        logic        clamped;
        logic        zero_step;
    } ctrl_out_t;

    longint    kp, ki, kd, limit;
    longint    integ, prev_err;
    ctrl_out_t pending_outputs[$];
    ctrl_out_t want;

    function automatic longint magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    // (a*b) >> 16 toward zero, magnitude capped at 2^48-1
    function automatic longint scaled_product(longint a, longint b);
        logic [127:0] ua, ub, full;
        longint m;
        ua = magnitude(a);
        ub = magnitude(b);
        full = (ua * ub) >> 16;
        m = (full > 128'(TermLim)) ? TermLim : longint'(full[63:0]);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic ctrl_out_t pid_update(logic clear, logic [31:0] err_bits,
                                             logic [23:0] dt_bits);
        longint err, dt, sum, acc, diff, quo, drv;
        logic with_i, with_d;
        ctrl_out_t res;
        res = '0;
        if (clear)
        begin
            integ = 0;
            prev_err = 0;
            return res;
        end
        err = $signed(err_bits);
        dt = dt_bits;
        // p not positive, or all gains positive, runs the full pid
        with_i = (kp <= 0) || (ki > 0);
        with_d = (kp <= 0) || (kd > 0);
        sum = scaled_product(kp, err);
        if (with_i)
        begin
            acc = integ + scaled_product(err, dt);
            if (acc > AccMax)
                acc = AccMax;
            else if (acc < AccMin)
                acc = AccMin;
            integ = acc;
            sum += scaled_product(ki, acc);
        end
        if (with_d)
        begin
            if (dt == 0)
                res.zero_step = 1'b1;
            else
            begin
                diff = err - prev_err;
                quo = (magnitude(diff) << 16) / dt;
                if (quo > AccMax)
                    quo = AccMax;
                sum += scaled_product(kd, (diff < 0) ? -quo : quo);
            end
            prev_err = err;
        end
        drv = sum;
        if (sum > limit)
        begin
            drv = limit;
            res.clamped = 1'b1;
        end
        else if (sum < -limit)
        begin
            drv = -limit;
            res.clamped = 1'b1;
        end
        res.drive = drv[31:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] expected_val,
                                        logic [31:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $error("%s: expected %0h, got %0h", name, expected_val, actual_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp = 0;
            ki = 0;
            kd = 0;
            limit = 0;
            integ = 0;
            prev_err = 0;
            pending_outputs.delete();
            mismatches = 0;
            results_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_P_GAIN:  kp = $signed(pwdata);
                    REG_I_GAIN:  ki = $signed(pwdata);
                    REG_D_GAIN:  kd = $signed(pwdata);
                    REG_MAX_OUT: limit = pwdata[30:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("drive: no transfer expected, got %0h", m_tdata[31:0]);
                    mismatches++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    check_field("drive", want.drive, m_tdata[31:0]);
                    check_field("clamped", 32'(want.clamped), 32'(m_tdata[32]));
                    check_field("zero_step", 32'(want.zero_step), 32'(m_tdata[33]));
                end
            end
            if (s_tvalid && s_tready)
                pending_outputs.push_back(pid_update(s_tuser == ITEM_CLEAR,
                                                     s_tdata[31:0], s_tdata[55:32]));
            results_due <= pending_outputs.size();
        end
    end

endmodule

[sim/pid_controller_clamped_tb.sv]
module pid_controller_clamped_tb
    import pidc_pkg::*, pidc_tb_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1_000_000;
    localparam int StallCycles = 400;

    typedef enum {
        MODE_PID,
        MODE_PI,
        MODE_PD,
        MODE_P,
        MODE_P_NONPOS
    } loop_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // error_in[31:0], time_step[55:32]
    logic        s_tuser = 1'b0; // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // drive[31:0], clamped[32], zero_step[33], zero

    int mismatches;
    int results_due;
    int send_idle = 0;
    int recv_idle = 0;
    logic stall_go = 1'b0;
    bit stall_taken = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;

    pid_controller_clamped DUT (.*);

    pid_controller_clamped_chk CHK (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        if (stall_go && !stall_taken)
        begin
            stall_taken <= 1'b1;
            stall_left <= StallCycles;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                              logic [31:0] lim);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(REG_P_GAIN, p);
        write_reg(REG_I_GAIN, i);
        write_reg(REG_D_GAIN, d);
        write_reg(REG_MAX_OUT, lim);
    endtask

    task automatic offer_item(item_kind_t kind, logic [31:0] err, logic [23:0] dt);
        if ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 70 : 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {dt, err};
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_gain(bit positive);
        if (positive)
            return ($urandom_range(3) == 0) ? 32'h7FFF_FFFF
                                             : 32'($urandom_range(1, 32'h0004_0000));
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'h8000_0000;
            default: return -32'($urandom_range(0, 32'h0004_0000));
        endcase
    endfunction

    // lean != 0 drives the integrator hard toward one rail
    function automatic logic [31:0] pick_error(int lean);
        int sel;
        logic [31:0] m;
        sel = $urandom_range(99);
        if (lean != 0 && sel < 95)
        begin
            m = 32'h7FFF_FFFF - $urandom_range(255);
            return (lean > 0) ? m : -m;
        end
        if (sel < 15)
        begin
            case ($urandom_range(4))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0;
                3: return 32'h1;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 45)
            return 32'($urandom_range(0, 32'h20_0000) - 32'h10_0000);
        return $urandom();
    endfunction

    function automatic logic [23:0] pick_step(int lean);
        int sel;
        sel = $urandom_range(99);
        if (lean != 0)
            return 24'hFF_FFFF - $urandom_range(255);
        if (sel < 10)
            return 24'h0;
        if (sel < 20)
            return 24'($urandom_range(1, 3));
        if (sel < 35)
            return 24'hFF_FFFF - $urandom_range(15);
        if (sel < 60)
            return 24'($urandom_range(1, 32'h1_0000));
        return 24'($urandom());
    endfunction

    task automatic pick_setting(bit integrating);
        loop_mode_t mode;
        logic [31:0] lim;
        mode = integrating ? loop_mode_t'($urandom_range(1))
                           : loop_mode_t'($urandom_range(4));
        case ($urandom_range(3))
            0: lim = 32'h0;
            1: lim = 32'h7FFF_FFFF;
            default: lim = {1'($urandom_range(1)), 31'($urandom() >> $urandom_range(20))};
        endcase
        case (mode)
            MODE_PID: load_gains(pick_gain(1), pick_gain(1), pick_gain(1), lim);
            MODE_PI:  load_gains(pick_gain(1), pick_gain(1), pick_gain(0), lim);
            MODE_PD:  load_gains(pick_gain(1), pick_gain(0), pick_gain(1), lim);
            MODE_P:   load_gains(pick_gain(1), pick_gain(0), pick_gain(0), lim);
            default:  load_gains(pick_gain(0), $urandom(), $urandom(), lim);
        endcase
    endtask

    initial
    begin
        int phase_items[5];
        int lean;
        item_kind_t kind;
        phase_items = '{150, 150, 300, 200, 200};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 28;
        recv_idle <= 45;

        // reset settings: all gains zero, limit zero
        offer_item(ITEM_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h8000_0000, 24'h0);

        load_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h7FFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h0001_0000, 24'h01_0000);
        offer_item(ITEM_UPDATE, 32'h8000_0000, 24'h00_0001);
        offer_item(ITEM_UPDATE, 32'h7FFF_FFFF, 24'h0);
        offer_item(ITEM_CLEAR, $urandom(), $urandom());
        offer_item(ITEM_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF);

        // p only: the derivative is skipped even with a zero step
        load_gains(32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h03E8_0000);
        offer_item(ITEM_UPDATE, 32'h7FFF_FFFF, 24'h0);
        offer_item(ITEM_UPDATE, 32'h8000_0000, 24'h5);
        offer_item(ITEM_UPDATE, 32'h0, 24'hFF_FFFF);

        load_gains(32'h0000_0001, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h8000_0000, 24'h0);
        offer_item(ITEM_UPDATE, 32'hFFFF_FFFF, 24'h1);

        // pd with a zero limit
        load_gains(32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        offer_item(ITEM_UPDATE, 32'h1234_5678, 24'h0);
        offer_item(ITEM_UPDATE, 32'h8000_0000, 24'h1);
        offer_item(ITEM_UPDATE, 32'h0, 24'hFF_FFFF);
        offer_item(ITEM_CLEAR, $urandom(), $urandom());

        load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h7FFF_FFFF, 24'hFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h8000_0000, 24'hFF_FFFF);
        offer_item(ITEM_UPDATE, 32'h0, 24'h0);
        offer_item(ITEM_CLEAR, $urandom(), $urandom());

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 2)
            begin
                send_idle = 45;
                recv_idle <= 28;
            end
            else if (ph == 4)
            begin
                send_idle = 0;
                recv_idle <= 0;
            end
            lean = (ph == 2) ? (($urandom_range(1) != 0) ? 1 : -1) : 0;
            pick_setting(ph == 2);
            if (ph == 1)
                stall_go <= 1'b1;
            for (int n = 0; n < phase_items[ph]; n++)
            begin
                if (ph == 3 && n == phase_items[ph] / 2)
                    wait_drained();
                kind = (lean == 0 && $urandom_range(99) < 4) ? ITEM_CLEAR : ITEM_UPDATE;
                offer_item(kind, pick_error(lean), pick_step(lean));
            end
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[pid_controller_clamped.f]
rtl/pidc_pkg.sv
rtl/pidc_div.sv
rtl/pidc_dp.sv
rtl/pidc_ctrl.sv
rtl/pid_controller_clamped.sv
sim/pidc_tb_pkg.sv
sim/pid_controller_clamped_chk.sv
sim/pid_controller_clamped_tb.sv
